@@ hw/rtl/slrg_pkg.sv @@
// Shared types, constants and helper functions for the subtractive lagged generator.
// Holds the microcode ROM used by slrg_sequencer and the datapath op codes.
// No dependencies.
package slrg_pkg;

   // arithmetic constants
   localparam logic [29:0] MODULUS      = 30'd1000000000;
   localparam logic [27:0] SEED_BASE    = 28'd161803398;
   localparam logic [5:0]  TABLE_LEN    = 6'd55;
   localparam logic [5:0]  SCATTER_STEP = 6'd21;
   localparam logic [5:0]  LAG_START    = 6'd31;
   localparam logic [5:0]  MIX_OFFSET   = 6'd30;
   // loop counts, loaded as count - 1
   localparam logic [5:0]  FILL_LAST    = 6'd53;
   localparam logic [5:0]  MIX_LAST     = 6'd54;
   localparam logic [1:0]  PASS_LAST    = 2'd3;

   // datapath operations
   typedef enum logic [3:0] {
      OP_LATCH     = 4'd0,
      OP_DRAW_RD   = 4'd1,
      OP_DRAW_WR   = 4'd2,
      OP_SEED_INIT = 4'd3,
      OP_FILL      = 4'd4,
      OP_MIX_INIT  = 4'd5,
      OP_MIX_RD    = 4'd6,
      OP_MIX_WR    = 4'd7,
      OP_SEED_DONE = 4'd8
   } op_type;

   // sequencer branch conditions
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_ALWAYS   = 3'd1,
      COND_WAIT_REQ = 3'd2,
      COND_OUT_FREE = 3'd3,
      COND_LOOP     = 3'd4,
      COND_LOOP2    = 3'd5
   } cond_type;

   typedef logic [3:0] pc_type;

   // program addresses
   localparam pc_type PC_IDLE      = 4'd0;
   localparam pc_type PC_DRAW_RD   = 4'd1;
   localparam pc_type PC_DRAW_WR   = 4'd2;
   localparam pc_type PC_SEED_INIT = 4'd3;
   localparam pc_type PC_FILL      = 4'd4;
   localparam pc_type PC_MIX_INIT  = 4'd5;
   localparam pc_type PC_MIX_RD    = 4'd6;
   localparam pc_type PC_MIX_WR    = 4'd7;
   localparam pc_type PC_SEED_DONE = 4'd8;
   localparam pc_type PC_LAST      = PC_SEED_DONE;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   // control from sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   exec;
   } ctrl_type;

   // status from datapath to sequencer
   typedef struct packed {
      logic cnt_zero;
      logic pass_zero;
      logic seeded;
   } status_type;

   // microcode ROM: one control word per program step
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      begin
         unique case (pc)
            PC_IDLE:      w = '{OP_LATCH,     COND_WAIT_REQ, PC_SEED_INIT};
            PC_DRAW_RD:   w = '{OP_DRAW_RD,   COND_NEXT,     PC_IDLE};
            PC_DRAW_WR:   w = '{OP_DRAW_WR,   COND_OUT_FREE, PC_IDLE};
            PC_SEED_INIT: w = '{OP_SEED_INIT, COND_NEXT,     PC_IDLE};
            PC_FILL:      w = '{OP_FILL,      COND_LOOP,     PC_FILL};
            PC_MIX_INIT:  w = '{OP_MIX_INIT,  COND_NEXT,     PC_IDLE};
            PC_MIX_RD:    w = '{OP_MIX_RD,    COND_NEXT,     PC_IDLE};
            PC_MIX_WR:    w = '{OP_MIX_WR,    COND_LOOP2,    PC_MIX_RD};
            PC_SEED_DONE: w = '{OP_SEED_DONE, COND_ALWAYS,   PC_DRAW_RD};
            default:      w = '{OP_LATCH,     COND_ALWAYS,   PC_IDLE};
         endcase
         return w;
      end
   endfunction

   // (a - b) mod 10^9 for a, b below 10^9
   function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
      logic [30:0] d;
      begin
         d = {1'b0, a} - {1'b0, b};
         if (a < b) begin
            d = d + {1'b0, MODULUS};
         end
         return d[29:0];
      end
   endfunction

   // pointer step, 55 wraps to 1
   function automatic logic [5:0] advance(input logic [5:0] p);
      logic [6:0] n;
      begin
         n = {1'b0, p} + 7'd1;
         if (n >= {1'b0, TABLE_LEN} + 7'd1) begin
            n = 7'd1;
         end
         return n[5:0];
      end
   endfunction

endpackage

@@ hw/rtl/slrg_sequencer.sv @@
// Microcoded sequencer: program counter, ROM lookup and branch logic.
// Depends on slrg_pkg (ROM, op codes, control and status structs).
module slrg_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  slrg_pkg::status_type status,
   output slrg_pkg::ctrl_type   ctrl
);

   slrg_pkg::pc_type    pc_ff;
   slrg_pkg::pc_type    pc_in;
   slrg_pkg::uword_type uw;
   logic                rsp_free;
   logic                need_seed;

   assign uw        = slrg_pkg::ucode_rom(pc_ff);
   assign rsp_free  = !rsp_valid || rsp_ready;
   assign need_seed = req_action || !status.seeded;
   assign req_ready = (pc_ff == slrg_pkg::PC_IDLE);

   // op enable: waits on a request beat or a free output register where the step needs one
   always_comb begin
      ctrl.op = uw.op;
      unique case (uw.cond)
         slrg_pkg::COND_WAIT_REQ: ctrl.exec = req_valid;
         slrg_pkg::COND_OUT_FREE: ctrl.exec = rsp_free;
         default:                 ctrl.exec = 1'b1;
      endcase
   end

   // next program step
   always_comb begin
      unique case (uw.cond)
         slrg_pkg::COND_NEXT:   pc_in = slrg_pkg::pc_type'(pc_ff + 4'd1);
         slrg_pkg::COND_ALWAYS: pc_in = uw.target;
         slrg_pkg::COND_WAIT_REQ: begin
            if (!req_valid) pc_in = pc_ff;
            else if (need_seed) pc_in = uw.target;
            else pc_in = slrg_pkg::pc_type'(pc_ff + 4'd1);
         end
         slrg_pkg::COND_OUT_FREE: pc_in = rsp_free ? uw.target : pc_ff;
         slrg_pkg::COND_LOOP:
            pc_in = !status.cnt_zero ? uw.target : slrg_pkg::pc_type'(pc_ff + 4'd1);
         slrg_pkg::COND_LOOP2:
            pc_in = (!status.cnt_zero || !status.pass_zero) ? uw.target
                                                            : slrg_pkg::pc_type'(pc_ff + 4'd1);
         default: pc_in = slrg_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= slrg_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // program counter stays inside the ROM
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= slrg_pkg::PC_LAST)
      else $error("pc outside program");

   // an accepted beat starts either a draw or a reseed
   a_accept_branch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (pc_ff == slrg_pkg::PC_DRAW_RD || pc_ff == slrg_pkg::PC_SEED_INIT))
      else $error("bad branch after accept");

endmodule

@@ hw/rtl/slrg_datapath.sv @@
// Datapath: lag table memory, pointers, fill registers, loop counters, output register.
// Depends on slrg_pkg; driven by the control word of slrg_sequencer.
module slrg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  slrg_pkg::ctrl_type   ctrl,
   input  logic [27:0]          req_seed,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [29:0]          rsp_value,
   output slrg_pkg::status_type status
);

   logic [29:0] lag_mem [0:55];
   logic [29:0] rd_a_ff;
   logic [29:0] rd_b_ff;
   logic [5:0]  raddr_a;
   logic [5:0]  raddr_b;
   logic        we;
   logic [5:0]  waddr;
   logic [29:0] wdata;

   logic [27:0] seed_ff;
   logic [29:0] start_ff;
   logic [29:0] fill_ff;
   logic [5:0]  pos_ff;
   logic [5:0]  ptr_a_ff;
   logic [5:0]  ptr_b_ff;
   logic [5:0]  cnt_ff;
   logic [1:0]  pass_ff;
   logic        seeded_ff;
   logic        rsp_valid_ff;
   logic [29:0] rsp_value_ff;

   logic [27:0] start_mag;
   logic [29:0] diff;
   logic [29:0] fill_next;
   logic [6:0]  pos_sum;
   logic [5:0]  pos_next;

   // seed distance from the base constant
   assign start_mag = (seed_ff <= slrg_pkg::SEED_BASE) ? (slrg_pkg::SEED_BASE - seed_ff)
                                                       : (seed_ff - slrg_pkg::SEED_BASE);
   assign diff      = slrg_pkg::sub_mod(rd_a_ff, rd_b_ff);
   assign fill_next = slrg_pkg::sub_mod(start_ff, fill_ff);
   assign pos_sum   = {1'b0, pos_ff} + {1'b0, slrg_pkg::SCATTER_STEP};
   assign pos_next  = (pos_sum >= {1'b0, slrg_pkg::TABLE_LEN})
                    ? 6'(pos_sum - {1'b0, slrg_pkg::TABLE_LEN}) : pos_sum[5:0];

   // read addresses: a draw reads at the stepped pointers
   assign raddr_a = (ctrl.op == slrg_pkg::OP_DRAW_RD) ? slrg_pkg::advance(ptr_a_ff) : ptr_a_ff;
   assign raddr_b = (ctrl.op == slrg_pkg::OP_DRAW_RD) ? slrg_pkg::advance(ptr_b_ff) : ptr_b_ff;

   // write port select
   always_comb begin
      we    = 1'b0;
      waddr = ptr_a_ff;
      wdata = diff;
      unique case (ctrl.op)
         slrg_pkg::OP_SEED_INIT: begin
            we    = 1'b1;
            waddr = slrg_pkg::TABLE_LEN;
            wdata = {2'b00, start_mag};
         end
         slrg_pkg::OP_FILL: begin
            we    = 1'b1;
            waddr = pos_ff;
            wdata = fill_ff;
         end
         slrg_pkg::OP_MIX_WR: we = 1'b1;
         slrg_pkg::OP_DRAW_WR: we = ctrl.exec;
         default: we = 1'b0;
      endcase
   end

   // lag table, one write and two registered reads per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         lag_mem[waddr] <= wdata;
      end
      rd_a_ff <= lag_mem[raddr_a];
      rd_b_ff <= lag_mem[raddr_b];
   end

   // payload registers for seeding
   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         case (ctrl.op)
            slrg_pkg::OP_LATCH: seed_ff <= req_seed;
            slrg_pkg::OP_SEED_INIT: begin
               start_ff <= {2'b00, start_mag};
               fill_ff  <= 30'd1;
               pos_ff   <= slrg_pkg::SCATTER_STEP;
            end
            slrg_pkg::OP_FILL: begin
               fill_ff  <= fill_next;
               start_ff <= fill_ff;
               pos_ff   <= pos_next;
            end
            default: begin
            end
         endcase
      end
   end

   // pointers, counters and seeded flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_a_ff  <= 6'd0;
         ptr_b_ff  <= slrg_pkg::LAG_START;
         cnt_ff    <= 6'd0;
         pass_ff   <= 2'd0;
         seeded_ff <= 1'b0;
      end else if (ctrl.exec) begin
         case (ctrl.op)
            slrg_pkg::OP_DRAW_RD: begin
               ptr_a_ff <= slrg_pkg::advance(ptr_a_ff);
               ptr_b_ff <= slrg_pkg::advance(ptr_b_ff);
            end
            slrg_pkg::OP_SEED_INIT: cnt_ff <= slrg_pkg::FILL_LAST;
            slrg_pkg::OP_FILL:      cnt_ff <= 6'(cnt_ff - 6'd1);
            slrg_pkg::OP_MIX_INIT: begin
               ptr_a_ff <= 6'd1;
               ptr_b_ff <= 6'd1 + slrg_pkg::MIX_OFFSET + 6'd1;
               cnt_ff   <= slrg_pkg::MIX_LAST;
               pass_ff  <= slrg_pkg::PASS_LAST;
            end
            slrg_pkg::OP_MIX_WR: begin
               ptr_a_ff <= slrg_pkg::advance(ptr_a_ff);
               ptr_b_ff <= slrg_pkg::advance(ptr_b_ff);
               if (cnt_ff == 6'd0) begin
                  cnt_ff  <= slrg_pkg::MIX_LAST;
                  pass_ff <= 2'(pass_ff - 2'd1);
               end else begin
                  cnt_ff <= 6'(cnt_ff - 6'd1);
               end
            end
            slrg_pkg::OP_SEED_DONE: begin
               ptr_a_ff  <= 6'd0;
               ptr_b_ff  <= slrg_pkg::LAG_START;
               seeded_ff <= 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.exec && ctrl.op == slrg_pkg::OP_DRAW_WR) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec && ctrl.op == slrg_pkg::OP_DRAW_WR) begin
         rsp_value_ff <= diff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign status.cnt_zero  = (cnt_ff == 6'd0);
   assign status.pass_zero = (pass_ff == 2'd0);
   assign status.seeded    = seeded_ff;

   // table writes never touch the unused entry zero
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (waddr != 6'd0 && waddr <= slrg_pkg::TABLE_LEN))
      else $error("table write out of range");

   // pointers stay within the table
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_a_ff <= slrg_pkg::TABLE_LEN && ptr_b_ff <= slrg_pkg::TABLE_LEN)
      else $error("pointer out of range");

   // once built, the table stays built
   a_seeded_sticky: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |=> seeded_ff)
      else $error("seeded flag dropped");

endmodule

@@ hw/rtl/subtractive_lagged_random_generator.sv @@
// Top level of the subtractive lagged random generator.
// Depends on slrg_pkg, slrg_sequencer and slrg_datapath.
//
// Subtractive lagged generator over a 55-word table modulo 10^9. A draw beat
// (action 0) returns the next value below one billion; a reseed beat (action 1)
// rebuilds the table from seed and then draws. The first draw after reset
// also seeds first. A draw steps from the accept to a table read, then a
// subtract and write back, as the table memory has a registered read port. A
// reseed runs the accept, 1 init, 54 scattered fills, 1 mixing setup, 4 x 55
// mixing steps (each a read, then a write through the single write port), 1
// finish, then the draw. A new request beat is taken while the previous result
// still waits in the output register; the sequencer stalls only when a second
// result would overwrite it.
module subtractive_lagged_random_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [27:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [29:0] rsp_value
);

   slrg_pkg::ctrl_type   ctrl;
   slrg_pkg::status_type status;

   slrg_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .ctrl       (ctrl)
   );

   slrg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_seed  (req_seed),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value),
      .status    (status)
   );

endmodule

@@ tb/tb_subtractive_lagged_random_generator.sv @@
// Self-checking testbench for the subtractive lagged random generator.
// Predicts every value with its own copy of the 55-word lag store; needs slrg_pkg and the RTL.
`timescale 1ns / 100ps

module tb_subtractive_lagged_random_generator;

   localparam logic ACTION_DRAW   = 1'b0;
   localparam logic ACTION_RESEED = 1'b1;
   localparam logic [27:0] SEED_MAX = 28'hFFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACTION_DRAW;
   logic [27:0] req_seed = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [29:0] rsp_value;

   // predictor state: lag words 1..55, two pointers, built flag
   logic [29:0] lag_words [1:55];
   logic [5:0]  read_idx = 6'd0;
   logic [5:0]  lag_idx = slrg_pkg::LAG_START;
   bit          words_built = 1'b0;

   logic [29:0] pending_values [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_left = 0;
   int          draws_sent = 0;
   int          reseeds_sent = 0;
   int          values_checked = 0;
   int          error_count = 0;

   subtractive_lagged_random_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_seed   (req_seed),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // (a - b) mod 10^9, both words already below 10^9
   function automatic logic [29:0] mod_sub_word(input logic [29:0] a, input logic [29:0] b);
      if (a >= b) begin
         return a - b;
      end
      return a + (slrg_pkg::MODULUS - b);
   endfunction

   function automatic logic [5:0] step_pointer(input logic [5:0] p);
      if (p >= slrg_pkg::TABLE_LEN) begin
         return 6'd1;
      end
      return p + 6'd1;
   endfunction

   // rebuild the lag words from a seed: scattered fills, then four mixing passes
   function automatic void rebuild_words(input logic [27:0] seed);
      logic [29:0] start;
      logic [29:0] fill;
      int pos;
      int other;
      if (seed <= slrg_pkg::SEED_BASE) begin
         start = 30'(slrg_pkg::SEED_BASE - seed);
      end else begin
         start = 30'(seed - slrg_pkg::SEED_BASE);
      end
      lag_words[55] = start;
      fill = 30'd1;
      for (int i = 1; i <= 54; i++) begin
         pos = (int'(slrg_pkg::SCATTER_STEP) * i) % int'(slrg_pkg::TABLE_LEN);
         lag_words[pos] = fill;
         fill = mod_sub_word(start, fill);
         start = lag_words[pos];
      end
      for (int pass = 0; pass < 4; pass++) begin
         for (int i = 1; i <= 55; i++) begin
            other = 1 + (i + int'(slrg_pkg::MIX_OFFSET)) % int'(slrg_pkg::TABLE_LEN);
            lag_words[i] = mod_sub_word(lag_words[i], lag_words[other]);
         end
      end
      read_idx = 6'd0;
      lag_idx = slrg_pkg::LAG_START;
      words_built = 1'b1;
   endfunction

   // value the block must return for one accepted request beat
   function automatic logic [29:0] next_random_value(input logic action, input logic [27:0] seed);
      logic [29:0] diff;
      if (action == ACTION_RESEED || !words_built) begin
         rebuild_words(seed);
      end
      read_idx = step_pointer(read_idx);
      lag_idx = step_pointer(lag_idx);
      diff = mod_sub_word(lag_words[read_idx], lag_words[lag_idx]);
      lag_words[read_idx] = diff;
      return diff;
   endfunction

   // offer one request beat from a falling edge, record its expected value, maybe idle
   task automatic send_beat(input logic action, input logic [27:0] seed);
      req_action = action;
      req_seed = seed;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_values.push_back(next_random_value(action, seed));
      if (action == ACTION_RESEED) begin
         reseeds_sent++;
      end else begin
         draws_sent++;
      end
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
   endtask

   // receiver: long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // compare each result beat with the oldest expected value
   always @(posedge clock) begin : check_results
      logic [29:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_values.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %0d", $time, rsp_value);
            error_count++;
         end else begin
            want = pending_values.pop_front();
            values_checked++;
            if (rsp_value !== want) begin
               $display("%0t: value mismatch, expected %0d, got %0d", $time, want, rsp_value);
               error_count++;
            end
         end
      end
   end

   // a draw straight after reset seeds from its own seed field
   task automatic test_first_draw_seeds();
      send_beat(ACTION_DRAW, 28'd4711);
      send_beat(ACTION_DRAW, SEED_MAX);
      send_beat(ACTION_DRAW, 28'd0);
   endtask

   // reseeds at and around the base seed, the field limits and alternating bits
   task automatic test_seed_extremes();
      logic [27:0] seeds [8];
      seeds = '{28'd0, 28'd1, slrg_pkg::SEED_BASE - 28'd1, slrg_pkg::SEED_BASE,
                slrg_pkg::SEED_BASE + 28'd1, SEED_MAX, 28'h5555555, 28'hAAAAAAA};
      foreach (seeds[k]) begin
         send_beat(ACTION_RESEED, seeds[k]);
         send_beat(ACTION_DRAW, ~seeds[k]);
      end
      // back-to-back reseeds
      send_beat(ACTION_RESEED, 28'd161803397);
      send_beat(ACTION_RESEED, 28'd161803397);
   endtask

   // mostly draws, occasional reseeds, seeds over the whole field
   task automatic test_random_stream(input int count, input int idle_pct, input int stall_pct);
      logic        action;
      logic [27:0] seed;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         action = ($urandom_range(99) < 4) ? ACTION_RESEED : ACTION_DRAW;
         if ($urandom_range(1) == 0) begin
            seed = 28'($urandom);
         end else begin
            seed = 28'($urandom_range(int'(slrg_pkg::SEED_BASE), 0));
         end
         send_beat(action, seed);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming;
   // the hold outlasts the reseed so the draws behind it fill the block
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 800;
      send_beat(ACTION_RESEED, 28'($urandom));
      for (int n = 0; n < 12; n++) begin
         send_beat(ACTION_DRAW, 28'($urandom));
      end
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      recv_stall_pct = 0;
      while (pending_values.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (pending_values.size() != 0) begin
         $display("%0t: %0d expected values never arrived", $time, pending_values.size());
         error_count++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_first_draw_seeds();
      test_seed_extremes();
      test_random_stream(150, 0, 0);
      test_random_stream(150, 71, 0);
      test_random_stream(150, 0, 71);
      test_output_backpressure();
      test_random_stream(150, 22, 22);

      @(negedge clock);
      req_valid = 1'b0;
      drain_results();

      $display("Run covered %0d draws and %0d reseeds: first-draw seeding, seed extremes,",
               draws_sent, reseeds_sent);
      $display("idle and stall phases and a long output hold-off; %0d values compared.",
               values_checked);
      if (error_count == 0) begin
         $display("tb_subtractive_lagged_random_generator: PASS");
      end else begin
         $display("tb_subtractive_lagged_random_generator: FAIL");
      end
      $finish;
   end

   // overall watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("%0t: timeout", $time);
      $display("tb_subtractive_lagged_random_generator: FAIL");
      $finish;
   end

endmodule

@@ subtractive_lagged_random_generator.f @@
hw/rtl/slrg_pkg.sv
hw/rtl/slrg_sequencer.sv
hw/rtl/slrg_datapath.sv
hw/rtl/subtractive_lagged_random_generator.sv
tb/tb_subtractive_lagged_random_generator.sv
